// ===== src/lcd_line_mode_sequencer_core_defines.svh =====
// assertion macros used by the sequencer core
`ifndef LCD_LINE_MODE_SEQUENCER_CORE_DEFINES_SVH
`define LCD_LINE_MODE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCDSEQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdseq check failed");

// next-cycle implication, checked outside reset
`define LCDSEQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdseq check failed");

`endif

// ===== src/lcdseq_pkg.sv =====
package lcdseq_pkg;

    localparam int LINE_W   = 8;
    localparam int CYCLE_W  = 9;
    localparam int ENA_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int VISIBLE_LINES_DEF   = 144;
    localparam int TOTAL_LINES_DEF     = 154;
    localparam int SEARCH_CYCLES_DEF   = 80;
    localparam int TRANSFER_CYCLES_DEF = 172;
    localparam int HBLANK_CYCLES_DEF   = 204;
    localparam int VBLANK_CYCLES_DEF   = 456;

    localparam logic [LINE_W-1:0] LINE_RESET = 8'hFF;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_COMPARE = 2'd0,
        CFG_STAT_ENABLES = 2'd1
    } cfg_idx_t;

    // enable bit positions within stat_int_enables
    localparam int ENA_HBLANK = 0;
    localparam int ENA_VBLANK = 1;
    localparam int ENA_SEARCH = 2;
    localparam int ENA_COIN   = 3;

    typedef struct packed {
        logic [LINE_W-1:0] line_compare;
        logic [ENA_W-1:0]  stat_int_enables;
    } cfg_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        mode_t             mode;
        logic              coin;
    } seq_state_t;

    typedef struct packed {
        logic [LINE_W-1:0]  line_out;
        mode_t              mode_out;
        logic               coincidence;
        logic               stat_irq;
        logic               vblank_irq;
        logic [CYCLE_W-1:0] cycles_added;
        logic               search_start;
        logic               transfer_start;
    } result_t;

endpackage

// ===== src/lcdseq_cfg.sv =====
module lcdseq_cfg
    import lcdseq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINE_COMPARE: cfg_next.line_compare = cfg_data;
                CFG_STAT_ENABLES: cfg_next.stat_int_enables = cfg_data[ENA_W-1:0];
                default:          cfg_next = cfg_reg;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// ===== src/lcdseq_step.sv =====
module lcdseq_step
    import lcdseq_pkg::*;
#(
    parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES     = TOTAL_LINES_DEF,
    parameter int SEARCH_CYCLES   = SEARCH_CYCLES_DEF,
    parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF,
    parameter int HBLANK_CYCLES   = HBLANK_CYCLES_DEF,
    parameter int VBLANK_CYCLES   = VBLANK_CYCLES_DEF
)
(
    input  logic [LINE_W-1:0] line_seen,
    input  seq_state_t        cur,
    input  cfg_t              cfg,
    output seq_state_t        nxt,
    output result_t           res
);

    localparam logic [LINE_W-1:0]  VIS_L  = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0]  TOT_L  = LINE_W'(TOTAL_LINES);
    localparam logic [CYCLE_W-1:0] SRC_C  = CYCLE_W'(SEARCH_CYCLES);
    localparam logic [CYCLE_W-1:0] XFR_C  = CYCLE_W'(TRANSFER_CYCLES);
    localparam logic [CYCLE_W-1:0] HBL_C  = CYCLE_W'(HBLANK_CYCLES);
    localparam logic [CYCLE_W-1:0] VBL_C  = CYCLE_W'(VBLANK_CYCLES);

    logic              restart;
    logic              blank_path;
    logic [LINE_W-1:0] line_inc;
    logic [LINE_W-1:0] line;
    mode_t             path_mode;
    mode_t             mode;
    logic              coin;

    always_comb
    begin
        restart  = (line_seen != cur.line) || (line_seen >= TOT_L) || (cur.line >= TOT_L);
        line_inc = line_seen + 1'b1;   // line_seen below total here, no wrap past 8 bits

        if (restart)
        begin
            line      = '0;
            path_mode = MODE_HBLANK;
        end
        else
        begin
            path_mode = cur.mode;
            if (cur.mode == MODE_HBLANK || cur.mode == MODE_VBLANK)
                line = (line_inc >= TOT_L) ? '0 : line_inc;
            else
                line = line_seen;
        end

        blank_path = (path_mode == MODE_HBLANK) || (path_mode == MODE_VBLANK);

        res = '0;
        if (line < VIS_L)
        begin
            if (blank_path)
            begin
                mode             = MODE_SEARCH;
                res.search_start = 1'b1;
                res.cycles_added = SRC_C;
            end
            else if (path_mode == MODE_SEARCH)
            begin
                mode               = MODE_TRANSFER;
                res.transfer_start = 1'b1;
                res.cycles_added   = XFR_C;
            end
            else
            begin
                mode             = MODE_HBLANK;
                res.cycles_added = HBL_C;
            end
        end
        else
        begin
            mode             = MODE_VBLANK;
            res.vblank_irq   = (line == VIS_L);
            res.cycles_added = VBL_C;
        end

        coin = (line == cfg.line_compare);

        // each enabled condition fires on its own rising edge
        res.stat_irq = (cfg.stat_int_enables[ENA_COIN] && coin && !cur.coin)
            || (cfg.stat_int_enables[ENA_SEARCH] && mode == MODE_SEARCH
                && cur.mode != MODE_SEARCH)
            || (cfg.stat_int_enables[ENA_VBLANK] && mode == MODE_VBLANK
                && cur.mode != MODE_VBLANK)
            || (cfg.stat_int_enables[ENA_HBLANK] && mode == MODE_HBLANK
                && cur.mode != MODE_HBLANK);

        res.line_out    = line;
        res.mode_out    = mode;
        res.coincidence = coin;

        nxt.line = line;
        nxt.mode = mode;
        nxt.coin = coin;
    end

endmodule

// ===== src/lcd_line_mode_sequencer_core.sv =====
// lcd line and mode sequencer
// in channel: one transaction per sequencer step, carrying line_seen, the value
//   now held in the line register (it may have been overwritten from outside)
// out channel: one transaction per step with line, mode, coincidence flag,
//   status and vertical-blank interrupt requests, clock cost and start pulses
// cfg channel: writes line_compare (index 0) or stat_int_enables (index 1);
//   cfg_ready is always high, other indexes are dropped; write only while idle
// latency: a step accepted at edge n is presented on the out channel after
//   edge n+1 (input register, then result register)
// throughput: one step per cycle, set by the single step of next-state logic
//   between the input register and the result register
// stalls: while out_ready is low the result register holds; the input register
//   still takes one more transaction, after which in_ready drops
// reset: config registers clear, line state goes to 255 so the first step
//   restarts at line 0 in sprite search, mode clears to hblank
`include "lcd_line_mode_sequencer_core_defines.svh"

module lcd_line_mode_sequencer_core
    import lcdseq_pkg::*;
#(
    parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES     = TOTAL_LINES_DEF,
    parameter int SEARCH_CYCLES   = SEARCH_CYCLES_DEF,
    parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF,
    parameter int HBLANK_CYCLES   = HBLANK_CYCLES_DEF,
    parameter int VBLANK_CYCLES   = VBLANK_CYCLES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [LINE_W-1:0]     line_seen,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LINE_W-1:0]     line_out,
    output logic [1:0]            mode_out,
    output logic                  coincidence,
    output logic                  stat_irq,
    output logic                  vblank_irq,
    output logic [CYCLE_W-1:0]    cycles_added,
    output logic                  search_start,
    output logic                  transfer_start
);

    cfg_t              cfg;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [LINE_W-1:0] line_seen_reg;

    // sequencer state, updated when a step moves into the result register
    seq_state_t        state_reg;
    seq_state_t        state_next;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           res_reg;
    result_t           res_next;

    logic              out_load;
    logic              step_go;

    lcdseq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcdseq_step #(
        .VISIBLE_LINES   (VISIBLE_LINES),
        .TOTAL_LINES     (TOTAL_LINES),
        .SEARCH_CYCLES   (SEARCH_CYCLES),
        .TRANSFER_CYCLES (TRANSFER_CYCLES),
        .HBLANK_CYCLES   (HBLANK_CYCLES),
        .VBLANK_CYCLES   (VBLANK_CYCLES)
    ) u_step (
        .line_seen (line_seen_reg),
        .cur       (state_reg),
        .cfg       (cfg),
        .nxt       (state_next),
        .res       (res_next)
    );

    // result register free when empty or being drained this cycle
    assign out_load = !out_valid_reg || out_ready;
    // a held step advances into the result register
    assign step_go  = in_valid_reg && out_load;
    assign in_ready = !in_valid_reg || out_load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{line: LINE_RESET, mode: MODE_HBLANK, coin: 1'b0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_go)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            line_seen_reg <= line_seen;
        if (step_go)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign line_out       = res_reg.line_out;
    assign mode_out       = res_reg.mode_out;
    assign coincidence    = res_reg.coincidence;
    assign stat_irq       = res_reg.stat_irq;
    assign vblank_irq     = res_reg.vblank_irq;
    assign cycles_added   = res_reg.cycles_added;
    assign search_start   = res_reg.search_start;
    assign transfer_start = res_reg.transfer_start;

    // state and presented result must agree after every step
    `LCDSEQ_ASSERT_NXT(a_state_matches_out, step_go,
        state_reg.line == res_reg.line_out && state_reg.mode == res_reg.mode_out)
    // a search pulse only accompanies sprite search
    `LCDSEQ_ASSERT_IMP(a_search_mode, out_valid_reg && res_reg.search_start,
        res_reg.mode_out == MODE_SEARCH && !res_reg.transfer_start)
    // vertical-blank interrupt only on the first blank line
    `LCDSEQ_ASSERT_IMP(a_vblank_line, out_valid_reg && res_reg.vblank_irq,
        res_reg.line_out == LINE_W'(VISIBLE_LINES) && res_reg.mode_out == MODE_VBLANK)
    // presented line always inside the frame
    `LCDSEQ_ASSERT_IMP(a_line_range, out_valid_reg,
        res_reg.line_out < LINE_W'(TOTAL_LINES))

endmodule

// ===== dv/lcd_line_mode_sequencer_checker.sv =====
module lcd_line_mode_sequencer_checker
    import lcdseq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [LINE_W-1:0]     line_seen,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [LINE_W-1:0]     line_out,
    input  logic [1:0]            mode_out,
    input  logic                  coincidence,
    input  logic                  stat_irq,
    input  logic                  vblank_irq,
    input  logic [CYCLE_W-1:0]    cycles_added,
    input  logic                  search_start,
    input  logic                  transfer_start,

    output logic [LINE_W-1:0]     line_held,
    output int                    steps_pending,
    output int                    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VISIBLE_LINES   = VISIBLE_LINES_DEF;
    localparam int TOTAL_LINES     = TOTAL_LINES_DEF;
    localparam int SEARCH_CYCLES   = SEARCH_CYCLES_DEF;
    localparam int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF;
    localparam int HBLANK_CYCLES   = HBLANK_CYCLES_DEF;
    localparam int VBLANK_CYCLES   = VBLANK_CYCLES_DEF;

    logic [LINE_W-1:0] compare_line;
    logic [ENA_W-1:0]  irq_enables;
    logic [LINE_W-1:0] line_q;
    mode_t             mode_q;
    logic              coin_q;
    result_t           steps_due [$];

    assign line_held = line_q;

    // advance the sequencer by one step and return what the block should report
    function automatic result_t step_sequencer(input logic [LINE_W-1:0] seen);
        result_t           res;
        mode_t             path;
        mode_t             next_mode;
        logic [LINE_W-1:0] ln;
        logic              coin;
        res  = '0;
        ln   = seen;
        path = mode_q;
        if (seen != line_q || seen >= TOTAL_LINES || line_q >= TOTAL_LINES)
        begin
            ln   = '0;
            path = MODE_HBLANK;
        end
        else if (path == MODE_HBLANK || path == MODE_VBLANK)
        begin
            ln = ln + 1'b1;
            if (ln >= TOTAL_LINES)
                ln = '0;
        end
        if (ln < VISIBLE_LINES)
        begin
            case (path)
                MODE_HBLANK, MODE_VBLANK:
                begin
                    next_mode = MODE_SEARCH;
                    res.search_start = 1'b1;
                    res.cycles_added = CYCLE_W'(SEARCH_CYCLES);
                end
                MODE_SEARCH:
                begin
                    next_mode = MODE_TRANSFER;
                    res.transfer_start = 1'b1;
                    res.cycles_added = CYCLE_W'(TRANSFER_CYCLES);
                end
                default:
                begin
                    next_mode = MODE_HBLANK;
                    res.cycles_added = CYCLE_W'(HBLANK_CYCLES);
                end
            endcase
        end
        else
        begin
            next_mode = MODE_VBLANK;
            res.vblank_irq = (ln == VISIBLE_LINES);
            res.cycles_added = CYCLE_W'(VBLANK_CYCLES);
        end
        coin = (ln == compare_line);
        res.stat_irq =
            (irq_enables[ENA_COIN] && coin && !coin_q) ||
            (irq_enables[ENA_SEARCH] && next_mode == MODE_SEARCH && mode_q != MODE_SEARCH) ||
            (irq_enables[ENA_VBLANK] && next_mode == MODE_VBLANK && mode_q != MODE_VBLANK) ||
            (irq_enables[ENA_HBLANK] && next_mode == MODE_HBLANK && mode_q != MODE_HBLANK);
        res.line_out    = ln;
        res.mode_out    = next_mode;
        res.coincidence = coin;
        line_q = ln;
        mode_q = next_mode;
        coin_q = coin;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            compare_line  = '0;
            irq_enables   = '0;
            line_q        = LINE_RESET;
            mode_q        = MODE_HBLANK;
            coin_q        = 1'b0;
            steps_due.delete();
            steps_pending = 0;
            mismatches    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LINE_COMPARE)
                    compare_line = cfg_data[LINE_W-1:0];
                else if (cfg_index == CFG_STAT_ENABLES)
                    irq_enables = cfg_data[ENA_W-1:0];
            end
            if (out_valid && out_ready)
            begin
                if (steps_due.size() == 0)
                begin
                    $error("result with no step outstanding: line_out %0d", line_out);
                    mismatches++;
                end
                else
                begin
                    want = steps_due.pop_front();
                    check_field("line_out", 9'(want.line_out), 9'(line_out));
                    check_field("mode_out", 9'(want.mode_out), 9'(mode_out));
                    check_field("coincidence", 9'(want.coincidence), 9'(coincidence));
                    check_field("stat_irq", 9'(want.stat_irq), 9'(stat_irq));
                    check_field("vblank_irq", 9'(want.vblank_irq), 9'(vblank_irq));
                    check_field("cycles_added", want.cycles_added, cycles_added);
                    check_field("search_start", 9'(want.search_start), 9'(search_start));
                    check_field("transfer_start", 9'(want.transfer_start),
                        9'(transfer_start));
                end
            end
            if (in_valid && in_ready)
                steps_due = {steps_due, step_sequencer(line_seen)};
            steps_pending = steps_due.size();
        end
    end

endmodule

// ===== dv/lcd_line_mode_sequencer_core_test.sv =====
module lcd_line_mode_sequencer_core_test
    import lcdseq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int PHASES         = 5;
    localparam int STEPS_PER_PHASE = 376;
    localparam int DRAIN_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int HOLD_AT_STEP   = 500;
    localparam int HOLD_CYCLES    = 250;
    localparam int CALM_FROM      = 1000;
    localparam int CALM_UNTIL     = 1300;

    // register indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LINE_COMPARE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [LINE_W-1:0]     line_seen = '0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [LINE_W-1:0]     line_out;
    logic [1:0]            mode_out;
    logic                  coincidence;
    logic                  stat_irq;
    logic                  vblank_irq;
    logic [CYCLE_W-1:0]    cycles_added;
    logic                  search_start;
    logic                  transfer_start;

    logic [LINE_W-1:0]     line_held;
    int                    steps_pending;
    int                    mismatches;

    int                    items_sent  = 0;
    int                    cycle_count = 0;
    logic                  calm;

    // per-phase settings; the last phase picks its registers at random
    logic [LINE_W-1:0]     phase_compare [PHASES] = '{8'd144, 8'd0, 8'd255, 8'd153, 8'd0};
    logic [CFG_DATA_W-1:0] phase_enables [PHASES] = '{8'h0F, 8'h00, 8'hFA, 8'h35, 8'h00};
    // chance per thousand that a step breaks the line sequence
    int                    phase_noise   [PHASES] = '{0, 3, 150, 0, 2};

    // hand-picked steps: restarts from search, transfer and hblank, out-of-range lines, coincidence edges
    logic [LINE_W-1:0]     directed_lines [22] = '{
        8'd0,   8'd0,  8'd0, 8'd1, 8'd1,   8'd1,
        8'd7,   8'd0,  8'd0, 8'd200, 8'd0, 8'd154,
        8'd0,   8'd255, 8'd0, 8'd0, 8'd0,  8'd1,
        8'd128, 8'd64, 8'd0, 8'd0
    };

    // a stretch where neither side idles
    assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_UNTIL);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    lcd_line_mode_sequencer_core dut (.*);

    lcd_line_mode_sequencer_checker checker_inst (.*);

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lcd_line_mode_sequencer_core: mismatch");
            $finish;
        end
    end

    // offer one step and hold it until the transaction completes;
    // returns on a falling edge with valid still up, so the caller either
    // presents the next step or drops valid in that same step
    task automatic send_step(input logic [LINE_W-1:0] value);
        while (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        line_seen <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // one register write; leaves a free falling edge so valid is never
    // dropped and raised in the same step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // stop offering steps and let every outstanding result come back
    task automatic drain();
        in_valid <= 1'b0;
        while (steps_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // result side: random back-pressure, one long hold-off to fill the pipe
    initial
    begin
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held_once && items_sent >= HOLD_AT_STEP)
            begin
                // sender keeps going meanwhile, so the block must stall its input
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    initial
    begin
        logic [LINE_W-1:0] step_line;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first step under reset settings: the held line starts out of range
        send_step(8'hFF);
        drain();

        write_reg(CFG_LINE_COMPARE, 8'd1);
        write_reg(CFG_STAT_ENABLES, 8'h0F);
        foreach (directed_lines[i])
            send_step(directed_lines[i]);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
            begin
                write_reg(CFG_LINE_COMPARE, CFG_DATA_W'($urandom_range(255)));
                write_reg(CFG_STAT_ENABLES, CFG_DATA_W'($urandom_range(255)));
            end
            else
            begin
                write_reg(CFG_LINE_COMPARE, phase_compare[ph]);
                write_reg(CFG_STAT_ENABLES, phase_enables[ph]);
            end
            // writes to unmapped indexes must leave both registers alone
            write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(255)));
            write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(255)));

            repeat (STEPS_PER_PHASE)
            begin
                // mostly follow the line the block holds, so whole frames
                // run through into vertical blank and wrap round
                if ($urandom_range(999) < phase_noise[ph])
                begin
                    case ($urandom_range(2))
                        0:       step_line = LINE_W'($urandom_range(255));
                        1:       step_line = LINE_W'($urandom_range(255, TOTAL_LINES_DEF));
                        default: step_line = line_held + 1'b1;
                    endcase
                end
                else
                    step_line = line_held;
                send_step(step_line);
            end
            drain();
        end

        if (mismatches == 0)
            $display("lcd_line_mode_sequencer_core: match");
        else
            $display("lcd_line_mode_sequencer_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/lcdseq_pkg.sv
src/lcdseq_cfg.sv
src/lcdseq_step.sv
src/lcd_line_mode_sequencer_core.sv
dv/lcd_line_mode_sequencer_checker.sv
dv/lcd_line_mode_sequencer_core_test.sv
